### design/integer_matrix_multiply_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Integer matrix multiply engine assertion macros
// Concurrent assertion helpers that compile away when assertions are off.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IMME_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define IMME_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define IMME_ASSERT_IMPL(label, clk, rst_n, prop)
`define IMME_NEVER(label, clk, rst_n, cond)
`endif
`endif

### design/imme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Integer matrix multiply engine package
// Shared types, opcodes, element type codes, register indices and helpers.
// ----------------------------------------------------------------------------
package imme_pkg;
    localparam logic [1:0] OP_LOAD_A = 2'd0;
    localparam logic [1:0] OP_LOAD_B = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    localparam logic [3:0] T_I4  = 4'd0;
    localparam logic [3:0] T_U4  = 4'd1;
    localparam logic [3:0] T_I8  = 4'd2;
    localparam logic [3:0] T_U8  = 4'd3;
    localparam logic [3:0] T_I16 = 4'd4;
    localparam logic [3:0] T_U16 = 4'd5;
    localparam logic [3:0] T_I32 = 4'd6;
    localparam logic [3:0] T_U32 = 4'd7;
    localparam logic [3:0] T_I64 = 4'd8;

    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;
    localparam logic [1:0] REG_TYPE  = 2'd3;

    localparam logic [63:0] NIB_MASK = 64'h0F;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [63:0] value;
    } t_cmd;

    function automatic logic [63:0] widen(input logic [63:0] raw, input logic [3:0] t);
        logic [63:0] v;
        begin
            case (t)
                T_I4:  v = {{60{raw[3]}}, raw[3:0]};
                T_U4:  v = {60'd0, raw[3:0]};
                T_I8:  v = {{56{raw[7]}}, raw[7:0]};
                T_U8:  v = {56'd0, raw[7:0]};
                T_I16: v = {{48{raw[15]}}, raw[15:0]};
                T_U16: v = {48'd0, raw[15:0]};
                T_I32: v = {{32{raw[31]}}, raw[31:0]};
                T_U32: v = {32'd0, raw[31:0]};
                default: v = raw;
            endcase
            return v;
        end
    endfunction

    function automatic logic [63:0] narrow(input logic [63:0] s, input logic [3:0] t);
        logic [63:0] r;
        logic        hi_zero;
        logic        hi_ones;
        begin
            hi_zero = (s[63:4] == 60'd0);
            hi_ones = (s[63:3] == {61{1'b1}});
            case (t)
                T_I4: begin
                    if (s[63]) r = hi_ones ? (s & NIB_MASK) : 64'h8;
                    else       r = (hi_zero && !s[3]) ? s : 64'h7;
                end
                T_U4: begin
                    if (s[63]) r = 64'd0;
                    else       r = hi_zero ? s : 64'hF;
                end
                T_I8, T_U8:   r = {56'd0, s[7:0]};
                T_I16, T_U16: r = {48'd0, s[15:0]};
                T_I32, T_U32: r = {32'd0, s[31:0]};
                default:      r = s;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

### design/imme_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module imme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### design/imme_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command front end
// Accepts input beats, drops unused opcodes and loads outside the array,
// and queues the rest for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module imme_front #(
    parameter int MAX_DIM = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  imme_pkg::t_cmd   i_cmd,
    output logic             o_valid,
    input  wire              i_ready,
    output imme_pkg::t_cmd   o_cmd
);
    imme_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           keep;
    logic           push;
    logic           pop;

    always_comb begin
        case (i_cmd.opcode)
            imme_pkg::OP_LOAD_A, imme_pkg::OP_LOAD_B:
                keep = ({1'b0, i_cmd.row} < 4'(MAX_DIM)) && ({1'b0, i_cmd.col} < 4'(MAX_DIM));
            imme_pkg::OP_START: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready && keep;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

### design/imme_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Compute back end
// Writes loads into the two stores; on start, walks i, j, p, reading one A and
// one B entry a cycle unless stalled, accumulating through a two-stage multiply.
// ----------------------------------------------------------------------------
module imme_back #(
    parameter int MAX_DIM = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  imme_pkg::t_cmd   i_cmd,
    input  wire [3:0]        i_rows,
    input  wire [3:0]        i_inner,
    input  wire [3:0]        i_cols,
    input  wire [3:0]        i_type,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [2:0]       o_out_row,
    output logic [2:0]       o_out_col,
    output logic [63:0]      o_product_value,
    output logic             o_last_flag,
    output logic             o_busy
);
    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]    r_state;
    logic [IW-1:0] r_i, r_j, r_p;
    logic [3:0]    r_m, r_n, r_k;
    logic [3:0]    r_t;
    logic          r_s1, r_s2, r_vacc;
    logic          r_ls1, r_ls2, r_lacc;
    logic          r_es1, r_es2, r_eacc;
    logic [IW-1:0] r_is1, r_is2, r_iacc;
    logic [IW-1:0] r_js1, r_js2, r_jacc;
    logic [63:0]   rd_a, rd_b, wa, wb;
    logic [63:0]   r_pp_ll;
    logic [31:0]   r_pp_lh, r_pp_hl;
    logic [63:0]   r_prod;
    logic [63:0]   r_acc;
    logic          r_ov;
    logic [2:0]    r_orow, r_ocol;
    logic [63:0]   r_oval;
    logic          r_olast;
    logic          we_a, we_b, start_go, out_fire;
    logic [AW-1:0] waddr, ra_addr, rb_addr;
    logic          p_last, j_last, i_last, issue, zero_k, stall;
    logic [3:0]    m_c, n_c, k_c, p_nx, j_nx, i_nx;

    assign m_c = (i_rows  > 4'(MAX_DIM)) ? 4'(MAX_DIM) : i_rows;
    assign n_c = (i_cols  > 4'(MAX_DIM)) ? 4'(MAX_DIM) : i_cols;
    assign k_c = (i_inner > 4'(MAX_DIM)) ? 4'(MAX_DIM) : i_inner;

    assign o_ready  = (r_state == S_IDLE);
    assign waddr    = {i_cmd.row[IW-1:0], i_cmd.col[IW-1:0]};
    assign we_a     = i_valid && o_ready && (i_cmd.opcode == imme_pkg::OP_LOAD_A);
    assign we_b     = i_valid && o_ready && (i_cmd.opcode == imme_pkg::OP_LOAD_B);
    assign start_go = i_valid && o_ready && (i_cmd.opcode == imme_pkg::OP_START)
                      && (m_c != 4'd0) && (n_c != 4'd0);
    assign ra_addr  = {r_i, r_p};
    assign rb_addr  = {r_p, r_j};

    assign p_nx   = 4'(r_p) + 4'd1;
    assign j_nx   = 4'(r_j) + 4'd1;
    assign i_nx   = 4'(r_i) + 4'd1;
    assign zero_k = (r_k == 4'd0);
    assign p_last = zero_k || (p_nx == r_k);
    assign j_last = (j_nx == r_n);
    assign i_last = (i_nx == r_m);

    assign out_fire = r_vacc && r_lacc;
    // Issue stalls from the last step of a sum until its result beat is accepted.
    assign stall = (r_s1 && r_ls1) || (r_s2 && r_ls2) || out_fire || r_ov;
    assign issue = (r_state == S_RUN) && !stall;

    assign wa = imme_pkg::widen(rd_a, r_t);
    assign wb = imme_pkg::widen(rd_b, r_t);

    imme_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(waddr), .i_wdata(i_cmd.value),
        .i_raddr(ra_addr), .o_rdata(rd_a)
    );
    imme_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(i_cmd.value),
        .i_raddr(rb_addr), .o_rdata(rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_s1 <= 1'b0; r_s2 <= 1'b0; r_vacc <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_s1 <= issue; r_s2 <= r_s1; r_vacc <= r_s2;
            if (out_fire) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: if (start_go) r_state <= S_RUN;
                S_RUN:  if (issue && p_last && j_last && i_last) r_state <= S_WAIT;
                S_WAIT: if (!stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Product lane: issue, store read, partial products, product, accumulate.
    always_ff @(posedge i_clk) begin
        if (start_go) begin
            r_m <= m_c; r_n <= n_c; r_k <= k_c; r_t <= i_type;
            r_i <= '0; r_j <= '0; r_p <= '0;
        end else if (issue) begin
            if (p_last) begin
                r_p <= '0;
                if (j_last) begin
                    r_j <= '0;
                    if (!i_last) r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end else begin
                r_p <= r_p + 1'b1;
            end
        end
        r_ls1 <= p_last; r_es1 <= i_last && j_last; r_is1 <= r_i; r_js1 <= r_j;
        r_ls2 <= r_ls1; r_es2 <= r_es1; r_is2 <= r_is1; r_js2 <= r_js1;
        r_lacc <= r_ls2; r_eacc <= r_es2; r_iacc <= r_is2; r_jacc <= r_js2;
        r_pp_ll <= 64'(wa[31:0]) * 64'(wb[31:0]);
        r_pp_lh <= wa[31:0] * wb[63:32];
        r_pp_hl <= wa[63:32] * wb[31:0];
        r_prod  <= r_pp_ll + {r_pp_lh + r_pp_hl, 32'd0};
        if (start_go) begin
            r_acc <= 64'd0;
        end else if (r_vacc) begin
            r_acc <= r_lacc ? 64'd0 : r_acc + r_prod;
        end
        if (out_fire) begin
            r_orow  <= 3'(r_iacc);
            r_ocol  <= 3'(r_jacc);
            r_oval  <= imme_pkg::narrow(zero_k ? 64'd0 : r_acc + r_prod, r_t);
            r_olast <= r_eacc;
        end
    end

    assign o_valid         = r_ov;
    assign o_out_row       = r_orow;
    assign o_out_col       = r_ocol;
    assign o_product_value = r_oval;
    assign o_last_flag     = r_olast;
    assign o_busy          = (r_state != S_IDLE);
endmodule
`default_nettype wire

### design/integer_matrix_multiply_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Each result is a sum over the inner length K; a K of 0 gives a zero result.
// The next sum does not issue until each result is accepted; loads stream
// one beat per cycle while no multiply runs.
// The back end takes its next command once the final result is accepted and it
// has gone from its wait state back to idle.
// Reset is synchronous and active low; the stores are not cleared.
// ----------------------------------------------------------------------------
// Integer matrix multiply engine
// Top level: configuration registers, command front end and compute back end.
// ----------------------------------------------------------------------------
`include "integer_matrix_multiply_engine_unit_assert.svh"
module integer_matrix_multiply_engine_unit #(
    parameter int MAX_DIM = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire [1:0]    i_cfg_index,
    input  wire [3:0]    i_cfg_data,
    input  wire          i_valid,
    output logic         o_ready,
    input  wire [1:0]    i_opcode,
    input  wire [2:0]    i_row_index,
    input  wire [2:0]    i_col_index,
    input  wire [63:0]   i_elem_value,
    output logic         o_valid,
    input  wire          i_ready,
    output logic [2:0]   o_out_row,
    output logic [2:0]   o_out_col,
    output logic [63:0]  o_product_value,
    output logic         o_last_flag
);
    logic [3:0]     r_rows, r_inner, r_cols, r_type;
    imme_pkg::t_cmd in_cmd, q_cmd;
    logic           q_valid, q_ready, busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 4'd8; r_inner <= 4'd8; r_cols <= 4'd8; r_type <= imme_pkg::T_I4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                imme_pkg::REG_ROWS:  r_rows  <= i_cfg_data;
                imme_pkg::REG_INNER: r_inner <= i_cfg_data;
                imme_pkg::REG_COLS:  r_cols  <= i_cfg_data;
                imme_pkg::REG_TYPE:  r_type  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_cmd = '{opcode: i_opcode, row: i_row_index, col: i_col_index,
                      value: i_elem_value};

    imme_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(in_cmd), .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    imme_back #(.MAX_DIM(MAX_DIM)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_ready(q_ready),
        .i_cmd(q_cmd), .i_rows(r_rows), .i_inner(r_inner), .i_cols(r_cols),
        .i_type(r_type), .o_valid(o_valid), .i_ready(i_ready),
        .o_out_row(o_out_row), .o_out_col(o_out_col),
        .o_product_value(o_product_value), .o_last_flag(o_last_flag), .o_busy(busy)
    );

    `IMME_NEVER(a_no_out_idle, i_clk, i_rst_n, o_valid && !busy)
    `IMME_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid)
    `IMME_NEVER(a_no_accept_busy, i_clk, i_rst_n, q_valid && q_ready && busy)
endmodule
`default_nettype wire

### dv/tb_integer_matrix_multiply_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer matrix multiply engine testbench
// Loads A and B, starts multiplies under a range of dimension and element type
// settings, predicts every C element and checks each result beat in order.
// Both sides idle at random; one long output hold-off; drains between phases.
// ----------------------------------------------------------------------------
module tb_integer_matrix_multiply_engine_unit;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [3:0] T_U64 = 4'd9;
    localparam logic [3:0] T_UNUSED = 4'd12;
    localparam int DIM_MAX = 8;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [63:0] value;
        logic        last;
    } t_c_elem;

    class t_gemm_scoreboard;
        logic [63:0] mat_a [DIM_MAX*DIM_MAX];
        logic [63:0] mat_b [DIM_MAX*DIM_MAX];
        bit          written_a [DIM_MAX*DIM_MAX];
        bit          written_b [DIM_MAX*DIM_MAX];
        logic [3:0]  rows;
        logic [3:0]  inner;
        logic [3:0]  cols;
        logic [3:0]  etype;
        t_c_elem     c_queue [$];
        int          errors;

        function new();
            rows = 4'd8;
            inner = 4'd8;
            cols = 4'd8;
            etype = imme_pkg::T_I4;
            errors = 0;
            foreach (written_a[i]) begin
                written_a[i] = 0;
                written_b[i] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [3:0] v);
            case (idx)
                imme_pkg::REG_ROWS:  rows = v;
                imme_pkg::REG_INNER: inner = v;
                imme_pkg::REG_COLS:  cols = v;
                imme_pkg::REG_TYPE:  etype = v;
                default: ;
            endcase
        endfunction

        function int dim(logic [3:0] d);
            return (d > DIM_MAX) ? DIM_MAX : int'(d);
        endfunction

        function int elem_bits();
            case (etype)
                imme_pkg::T_I4, imme_pkg::T_U4:   return 4;
                imme_pkg::T_I8, imme_pkg::T_U8:   return 8;
                imme_pkg::T_I16, imme_pkg::T_U16: return 16;
                imme_pkg::T_I32, imme_pkg::T_U32: return 32;
                default:                          return 64;
            endcase
        endfunction

        function logic [63:0] elem_mask();
            int w;
            w = elem_bits();
            return (w == 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
        endfunction

        function logic [63:0] extend(logic [63:0] raw);
            logic [63:0] m;
            logic [63:0] v;
            int          w;
            w = elem_bits();
            m = elem_mask();
            v = raw & m;
            if (w < 64 && etype < 4'd10 && !etype[0] && v[w-1])
                v = v | ~m;
            return v;
        endfunction

        function logic [63:0] reduce(logic [63:0] sum);
            logic [63:0] r;
            if (etype == imme_pkg::T_I4) begin
                if (sum[63])
                    r = ($signed(sum) >= -64'sd8) ? sum : 64'hFFFF_FFFF_FFFF_FFF8;
                else
                    r = (sum > 64'd7) ? 64'd7 : sum;
                return r & 64'hF;
            end
            if (etype == imme_pkg::T_U4) begin
                if (sum[63])
                    return 64'd0;
                return (sum > 64'd15) ? 64'd15 : sum;
            end
            return sum & elem_mask();
        endfunction

        function void note_input(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                                 logic [63:0] val);
            int          m;
            int          k;
            int          n;
            logic [63:0] sum;
            t_c_elem     e;
            if (op == imme_pkg::OP_LOAD_A) begin
                mat_a[row*DIM_MAX+col] = val;
                written_a[row*DIM_MAX+col] = 1;
            end else if (op == imme_pkg::OP_LOAD_B) begin
                mat_b[row*DIM_MAX+col] = val;
                written_b[row*DIM_MAX+col] = 1;
            end else if (op == imme_pkg::OP_START) begin
                m = dim(rows);
                k = dim(inner);
                n = dim(cols);
                for (int i = 0; i < m; i++) begin
                    for (int j = 0; j < n; j++) begin
                        sum = 64'd0;
                        for (int p = 0; p < k; p++)
                            sum = sum + extend(mat_a[i*DIM_MAX+p]) *
                                  extend(mat_b[p*DIM_MAX+j]);
                        e.row = i[2:0];
                        e.col = j[2:0];
                        e.value = reduce(sum);
                        e.last = (i == m - 1) && (j == n - 1);
                        c_queue.push_back(e);
                    end
                end
            end
        endfunction

        function void check_result(logic [2:0] row, logic [2:0] col, logic [63:0] val,
                                   logic last);
            t_c_elem e;
            if (c_queue.size() == 0) begin
                $display("%0t: unexpected result beat row %0d col %0d value %h",
                         $time, row, col, val);
                errors++;
                return;
            end
            e = c_queue.pop_front();
            if (row !== e.row) begin
                $display("%0t: out_row expected %0d actual %0d", $time, e.row, row);
                errors++;
            end
            if (col !== e.col) begin
                $display("%0t: out_col expected %0d actual %0d", $time, e.col, col);
                errors++;
            end
            if (val !== e.value) begin
                $display("%0t: product_value expected %h actual %h", $time, e.value, val);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last_flag expected %0b actual %0b", $time, e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return c_queue.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [3:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_opcode;
    logic [2:0]  i_row_index;
    logic [2:0]  i_col_index;
    logic [63:0] i_elem_value;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_out_row;
    logic [2:0]  o_out_col;
    logic [63:0] o_product_value;
    logic        o_last_flag;

    t_gemm_scoreboard sb;
    bit               quiet;
    bit               hold_req;
    int               cycles;

    integer_matrix_multiply_engine_unit i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_opcode(i_opcode),
        .i_row_index(i_row_index),
        .i_col_index(i_col_index),
        .i_elem_value(i_elem_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_out_row(o_out_row),
        .o_out_col(o_out_col),
        .o_product_value(o_product_value),
        .o_last_flag(o_last_flag)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_input(i_opcode, i_row_index, i_col_index, i_elem_value);
            if (o_valid && i_ready)
                sb.check_result(o_out_row, o_out_col, o_product_value, o_last_flag);
        end
    end

    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic idle_gap(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_item(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                             logic [63:0] val);
        if (!quiet && $urandom_range(0, 4) == 0)
            idle_gap($urandom_range(1, 15));
        i_valid <= 1'b1;
        i_opcode <= op;
        i_row_index <= row;
        i_col_index <= col;
        i_elem_value <= val;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 6))
            0:       return 64'd0;
            1:       return {64{1'b1}};
            2:       return {1'b1, 63'd0} | (64'd1 << $urandom_range(0, 62));
            3:       return {{60{$urandom_range(0, 1) == 1}}, 4'($urandom_range(0, 15))};
            4:       return 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic program_dims(logic [3:0] m, logic [3:0] k, logic [3:0] n, logic [3:0] t);
        logic [3:0] vals [4];
        vals = '{m, k, n, t};
        wait_drain();
        repeat (20) @(posedge i_clk);
        for (int r = 0; r < 4; r++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= r[1:0];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            sb.set_reg(r[1:0], vals[r]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic ensure_loaded();
        int m;
        int k;
        int n;
        m = sb.dim(sb.rows);
        k = sb.dim(sb.inner);
        n = sb.dim(sb.cols);
        for (int i = 0; i < m; i++)
            for (int p = 0; p < k; p++)
                if (!sb.written_a[i*DIM_MAX+p])
                    send_item(imme_pkg::OP_LOAD_A, i[2:0], p[2:0], rand_value());
        for (int p = 0; p < k; p++)
            for (int j = 0; j < n; j++)
                if (!sb.written_b[p*DIM_MAX+j])
                    send_item(imme_pkg::OP_LOAD_B, p[2:0], j[2:0], rand_value());
    endtask

    function automatic logic [2:0] pick(int d);
        return (d > 0) ? 3'($urandom_range(0, d - 1)) : 3'($urandom_range(0, 7));
    endfunction

    task automatic run_random(int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 9);
            if (r < 4)
                send_item(imme_pkg::OP_LOAD_A, pick(sb.dim(sb.rows)),
                          pick(sb.dim(sb.inner)), rand_value());
            else if (r < 7)
                send_item(imme_pkg::OP_LOAD_B, pick(sb.dim(sb.inner)),
                          pick(sb.dim(sb.cols)), rand_value());
            else if (r == 7)
                send_item($urandom_range(0, 1) ? OP_NONE : imme_pkg::OP_LOAD_B,
                          3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rand_value());
            else begin
                ensure_loaded();
                send_item(imme_pkg::OP_START, 3'($urandom_range(0, 7)),
                          3'($urandom_range(0, 7)), rand_value());
            end
        end
    endtask

    initial begin
        logic [3:0] ph_m [11];
        logic [3:0] ph_k [11];
        logic [3:0] ph_n [11];
        logic [3:0] ph_t [11];
        logic [63:0] edge_vals [6];
        sb = new();
        cycles = 0;
        quiet = 0;
        hold_req = 0;
        ph_m = '{4'd3, 4'd0, 4'd2, 4'd9, 4'd1, 4'd2, 4'd3, 4'd2, 4'd2, 4'd8, 4'd15};
        ph_k = '{4'd2, 4'd2, 4'd0, 4'd1, 4'd8, 4'd2, 4'd3, 4'd4, 4'd2, 4'd8, 4'd15};
        ph_n = '{4'd3, 4'd2, 4'd2, 4'd1, 4'd15, 4'd2, 4'd3, 4'd2, 4'd3, 4'd8, 4'd15};
        ph_t = '{imme_pkg::T_U4, imme_pkg::T_I8, imme_pkg::T_U8, imme_pkg::T_I16,
                 imme_pkg::T_U16, imme_pkg::T_I32, imme_pkg::T_U32, imme_pkg::T_I64,
                 T_U64, T_UNUSED, imme_pkg::T_U4};
        edge_vals = '{64'h7, 64'h8, 64'hF, 64'd0, {64{1'b1}}, 64'h7FFF_FFFF_FFFF_FFFF};
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= imme_pkg::REG_ROWS;
        i_cfg_data <= 4'd0;
        i_valid <= 1'b0;
        i_opcode <= imme_pkg::OP_LOAD_A;
        i_row_index <= 3'd0;
        i_col_index <= 3'd0;
        i_elem_value <= 64'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_dims(4'd2, 4'd3, 4'd2, imme_pkg::T_I4);
        for (int i = 0; i < 6; i++)
            send_item(imme_pkg::OP_LOAD_A, 3'(i / 3), 3'(i % 3), edge_vals[i]);
        for (int i = 0; i < 6; i++)
            send_item(imme_pkg::OP_LOAD_B, 3'(i / 2), 3'(i % 2), edge_vals[5 - i]);
        send_item(OP_NONE, 3'd7, 3'd7, {64{1'b1}});
        send_item(imme_pkg::OP_START, 3'd0, 3'd0, 64'd0);
        send_item(imme_pkg::OP_LOAD_A, 3'd7, 3'd7, 64'h8000_0000_0000_0000);
        send_item(imme_pkg::OP_LOAD_B, 3'd7, 3'd7, 64'h7FFF_FFFF_FFFF_FFF8);
        send_item(imme_pkg::OP_LOAD_A, 3'd0, 3'd0, 64'h8);
        send_item(imme_pkg::OP_LOAD_A, 3'd0, 3'd1, 64'h8);
        send_item(imme_pkg::OP_LOAD_A, 3'd0, 3'd2, 64'h8);
        send_item(imme_pkg::OP_START, 3'd7, 3'd7, {64{1'b1}});
        run_random(12);

        for (int ph = 0; ph < 11; ph++) begin
            program_dims(ph_m[ph], ph_k[ph], ph_n[ph], ph_t[ph]);
            if (ph == 10)
                quiet = 1;
            ensure_loaded();
            if (ph == 9)
                hold_req = 1;
            send_item(imme_pkg::OP_START, 3'd0, 3'd0, 64'd0);
            if (ph == 9) begin
                for (int i = 0; i < 30; i++)
                    send_item(imme_pkg::OP_LOAD_B, 3'($urandom_range(0, 7)),
                              3'($urandom_range(0, 7)), rand_value());
                send_item(imme_pkg::OP_START, 3'd0, 3'd0, 64'd0);
                wait_drain();
            end
            run_random(4);
        end

        wait_drain();
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
